FILE: hw/rtl/quaternion_to_euler_angles_top_assert.svh
// assertion macros for the quaternion to euler angle block
`ifndef QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_TOP_ASSERT_SVH

// condition holds at every clock edge out of reset
`define QTE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// condition holds whenever the qualifier is high
`define QTE_ASSERT_WHEN(label, clk, rst_n, qual, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (qual) |-> (cond)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/qte_pkg.sv
// types, constants and the arctangent table shared by the pose angle pipeline
package qte_pkg;

  localparam int unsigned QW     = 16;
  localparam int unsigned PW     = 32;
  localparam int unsigned AW     = 16;
  localparam int unsigned PROD_W = 2 * QW;
  localparam int unsigned RW     = 30;
  localparam int unsigned SQ_W   = 58;
  localparam int unsigned ROOT_W = SQ_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 3;
  localparam int unsigned CW     = 34;
  localparam int unsigned ZW     = 34;
  localparam int unsigned LANES  = 3;
  localparam int unsigned ATAN_LEN = 24;

  localparam logic signed [ZW-1:0] HALF_PI   = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0] ROUND_ADD = ZW'(64'sd65536);
  localparam logic signed [ZW-1:0] ANGLE_MAX = ZW'(64'sd25736);
  localparam logic signed [ZW-1:0] ANGLE_MIN = -ANGLE_MAX;

  typedef struct packed {
    logic signed [RW-1:0] r00;
    logic signed [RW-1:0] r10;
    logic signed [RW-1:0] r20;
    logic signed [RW-1:0] r21;
    logic signed [RW-1:0] r22;
  } rot_t;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] z;
  } pos_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = ZW'(64'sd843314856);
      5'd1:  v = ZW'(64'sd497837829);
      5'd2:  v = ZW'(64'sd263043836);
      5'd3:  v = ZW'(64'sd133525158);
      5'd4:  v = ZW'(64'sd67021686);
      5'd5:  v = ZW'(64'sd33543515);
      5'd6:  v = ZW'(64'sd16775850);
      5'd7:  v = ZW'(64'sd8388437);
      5'd8:  v = ZW'(64'sd4194282);
      5'd9:  v = ZW'(64'sd2097149);
      5'd10: v = ZW'(64'sd1048575);
      5'd11: v = ZW'(64'sd524287);
      5'd12: v = ZW'(64'sd262143);
      5'd13: v = ZW'(64'sd131071);
      5'd14: v = ZW'(64'sd65535);
      5'd15: v = ZW'(64'sd32767);
      5'd16: v = ZW'(64'sd16383);
      5'd17: v = ZW'(64'sd8191);
      5'd18: v = ZW'(64'sd4095);
      5'd19: v = ZW'(64'sd2047);
      5'd20: v = ZW'(64'sd1023);
      5'd21: v = ZW'(64'sd511);
      5'd22: v = ZW'(64'sd255);
      5'd23: v = ZW'(64'sd127);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/quaternion_to_euler_angles_top.sv
// Pose sample to roll, pitch and yaw. Takes one sample per cycle when not stalled and
// returns one result per sample, in order, after quaternion products and matrix entries,
// a bit-per-stage square root for the pitch denominator, a pre-rotation stage,
// CORDIC_STEPS cordic stages and a rounding stage. The whole pipeline advances together
// whenever the output register is empty or being taken, so a stall on the master side
// holds every stage. Angles are Q3.13 radians clamped to plus or minus pi; the position
// passes through unchanged.
module quaternion_to_euler_angles_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, pos_z
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // roll_angle, pitch_angle, yaw_angle, out_x, out_y, out_z
  output logic [143:0] m_axis_tdata
);
  import qte_pkg::*;

  logic en;
  logic mat_valid, sq_valid, cor_valid;
  rot_t mat_rot, sq_rot;
  pos_t in_pos, mat_pos, sq_pos, cor_pos;
  logic [SQ_W-1:0] sumsq;
  logic [ROOT_W-1:0] root;
  logic signed [CW-1:0] y_in [LANES];
  logic signed [CW-1:0] x_in [LANES];
  logic signed [AW-1:0] angle [LANES];

  assign en            = !cor_valid || m_axis_tready;
  assign s_axis_tready = en;

  assign in_pos.x = s_axis_tdata[95:64];
  assign in_pos.y = s_axis_tdata[127:96];
  assign in_pos.z = s_axis_tdata[159:128];

  qte_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .qx_i    (s_axis_tdata[15:0]),
    .qy_i    (s_axis_tdata[31:16]),
    .qz_i    (s_axis_tdata[47:32]),
    .qw_i    (s_axis_tdata[63:48]),
    .pos_i   (in_pos),
    .valid_o (mat_valid),
    .rot_o   (mat_rot),
    .sumsq_o (sumsq),
    .pos_o   (mat_pos)
  );

  qte_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mat_valid),
    .rad_i   (sumsq),
    .rot_i   (mat_rot),
    .pos_i   (mat_pos),
    .valid_o (sq_valid),
    .root_o  (root),
    .rot_o   (sq_rot),
    .pos_o   (sq_pos)
  );

  assign y_in[0] = CW'(sq_rot.r21);
  assign x_in[0] = CW'(sq_rot.r22);
  assign y_in[1] = -CW'(sq_rot.r20);
  assign x_in[1] = CW'({1'b0, root});
  assign y_in[2] = CW'(sq_rot.r10);
  assign x_in[2] = CW'(sq_rot.r00);

  qte_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .y_i     (y_in),
    .x_i     (x_in),
    .pos_i   (sq_pos),
    .valid_o (cor_valid),
    .angle_o (angle),
    .pos_o   (cor_pos)
  );

  assign m_axis_tvalid = cor_valid;
  assign m_axis_tdata  = {cor_pos.z, cor_pos.y, cor_pos.x, angle[2], angle[1], angle[0]};

`include "quaternion_to_euler_angles_top_assert.svh"

  `QTE_ASSERT_ALWAYS(a_ready_follows_output, clk_i, rst_ni, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `QTE_ASSERT_WHEN(a_roll_in_range, clk_i, rst_ni, m_axis_tvalid, ($signed(m_axis_tdata[15:0]) <= 16'sd25736) && ($signed(m_axis_tdata[15:0]) >= -16'sd25736))
  `QTE_ASSERT_WHEN(a_pitch_in_range, clk_i, rst_ni, m_axis_tvalid, ($signed(m_axis_tdata[31:16]) <= 16'sd14400) && ($signed(m_axis_tdata[31:16]) >= -16'sd14400))

endmodule

FILE: hw/rtl/qte_matrix.sv
// quaternion products, rotation matrix entries and the pitch radicand
module qte_matrix (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [qte_pkg::QW-1:0] qx_i,
  input  logic signed [qte_pkg::QW-1:0] qy_i,
  input  logic signed [qte_pkg::QW-1:0] qz_i,
  input  logic signed [qte_pkg::QW-1:0] qw_i,
  input  qte_pkg::pos_t               pos_i,
  output logic                        valid_o,
  output qte_pkg::rot_t               rot_o,
  output logic [qte_pkg::SQ_W-1:0]    sumsq_o,
  output qte_pkg::pos_t               pos_o
);
  import qte_pkg::*;

  localparam int unsigned SW = PROD_W + 3;
  localparam logic signed [SW-1:0] ONE_Q28 = SW'(64'sd268435456);

  function automatic logic signed [RW-1:0] entry(input logic signed [PROD_W-1:0] a,
                                                 input logic signed [PROD_W-1:0] b,
                                                 input logic diag);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] t;
    s = SW'(a) + SW'(b);
    t = (s <<< 1) - (diag ? ONE_Q28 : '0);
    return RW'(t >>> 4);
  endfunction

  logic valid1_q, valid2_q, valid3_q, valid4_q;
  logic signed [PROD_W-1:0] ww_q, xx_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q, zz_q;
  pos_t pos1_q, pos2_q, pos3_q, pos4_q;
  rot_t rot2_q, rot3_q, rot4_q;
  logic signed [2*RW-1:0] sq21_q, sq22_q;
  logic [SQ_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
      valid3_q <= valid2_q;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ww_q <= qw_i * qw_i;
      xx_q <= qx_i * qx_i;
      xy_q <= qx_i * qy_i;
      wz_q <= qw_i * qz_i;
      xz_q <= qx_i * qz_i;
      wy_q <= qw_i * qy_i;
      yz_q <= qy_i * qz_i;
      wx_q <= qw_i * qx_i;
      zz_q <= qz_i * qz_i;
      pos1_q <= pos_i;

      rot2_q.r00 <= entry(ww_q, xx_q, 1'b1);
      rot2_q.r10 <= entry(xy_q, wz_q, 1'b0);
      rot2_q.r20 <= entry(xz_q, -wy_q, 1'b0);
      rot2_q.r21 <= entry(yz_q, wx_q, 1'b0);
      rot2_q.r22 <= entry(ww_q, zz_q, 1'b1);
      pos2_q <= pos1_q;

      sq21_q <= rot2_q.r21 * rot2_q.r21;
      sq22_q <= rot2_q.r22 * rot2_q.r22;
      rot3_q <= rot2_q;
      pos3_q <= pos2_q;

      sum_q  <= {1'b0, sq21_q[SQ_W-2:0]} + {1'b0, sq22_q[SQ_W-2:0]};
      rot4_q <= rot3_q;
      pos4_q <= pos3_q;
    end
  end

  assign valid_o = valid4_q;
  assign rot_o   = rot4_q;
  assign sumsq_o = sum_q;
  assign pos_o   = pos4_q;

endmodule

FILE: hw/rtl/qte_isqrt.sv
// pipelined integer square root, one root bit per stage
module qte_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [qte_pkg::SQ_W-1:0]    rad_i,
  input  qte_pkg::rot_t               rot_i,
  input  qte_pkg::pos_t               pos_i,
  output logic                        valid_o,
  output logic [qte_pkg::ROOT_W-1:0]  root_o,
  output qte_pkg::rot_t               rot_o,
  output qte_pkg::pos_t               pos_o
);
  import qte_pkg::*;

  logic              valid_s [ROOT_W+1];
  logic [SQ_W-1:0]   rad_s   [ROOT_W+1];
  logic [REM_W-1:0]  rem_s   [ROOT_W+1];
  logic [ROOT_W-1:0] root_s  [ROOT_W+1];
  rot_t              rot_s   [ROOT_W+1];
  pos_t              pos_s   [ROOT_W+1];

  assign valid_s[0] = valid_i;
  assign rad_s[0]   = rad_i;
  assign rem_s[0]   = '0;
  assign root_s[0]  = '0;
  assign rot_s[0]   = rot_i;
  assign pos_s[0]   = pos_i;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_n;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign rem_n = {rem_s[k][REM_W-3:0], rad_s[k][SQ_W-1:SQ_W-2]};
    assign trial = REM_W'({root_s[k], 2'b01});
    assign ge    = rem_n >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_s[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_s[k+1] <= valid_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_s[k+1]  <= rad_s[k] << 2;
        rem_s[k+1]  <= ge ? rem_n - trial : rem_n;
        root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
        rot_s[k+1]  <= rot_s[k];
        pos_s[k+1]  <= pos_s[k];
      end
    end
  end

  assign valid_o = valid_s[ROOT_W];
  assign root_o  = root_s[ROOT_W];
  assign rot_o   = rot_s[ROOT_W];
  assign pos_o   = pos_s[ROOT_W];

endmodule

FILE: hw/rtl/qte_cordic.sv
// three-lane pipelined vectoring cordic with rounding and saturation
module qte_cordic #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [qte_pkg::CW-1:0] y_i [qte_pkg::LANES],
  input  logic signed [qte_pkg::CW-1:0] x_i [qte_pkg::LANES],
  input  qte_pkg::pos_t                 pos_i,
  output logic                          valid_o,
  output logic signed [qte_pkg::AW-1:0] angle_o [qte_pkg::LANES],
  output qte_pkg::pos_t                 pos_o
);
  import qte_pkg::*;

  // pre-rotation stage, one stage per iteration, rounding stage
  localparam int unsigned LAST = CORDIC_STEPS + 2;

  logic valid_s [LAST+1];
  pos_t pos_s   [LAST+1];

  assign valid_s[0] = valid_i;
  assign pos_s[0]   = pos_i;

  for (genvar s = 0; s <= LAST; s++) begin : g_ctl
    if (s < LAST) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_s[s+1] <= 1'b0;
        end else if (en_i) begin
          valid_s[s+1] <= valid_s[s];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pos_s[s+1] <= pos_s[s];
        end
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [CW-1:0] x_s  [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_s  [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_s  [CORDIC_STEPS+1];
    logic                 zv_s [CORDIC_STEPS+1];
    logic signed [ZW-1:0] q;
    logic signed [AW-1:0] ang_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zv_s[0] <= (x_i[l] == '0) && (y_i[l] == '0);
        if (x_i[l][CW-1] && !y_i[l][CW-1]) begin
          x_s[0] <= y_i[l];
          y_s[0] <= -x_i[l];
          z_s[0] <= HALF_PI;
        end else if (x_i[l][CW-1]) begin
          x_s[0] <= -y_i[l];
          y_s[0] <= x_i[l];
          z_s[0] <= -HALF_PI;
        end else begin
          x_s[0] <= x_i[l];
          y_s[0] <= y_i[l];
          z_s[0] <= '0;
        end
      end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic signed [CW-1:0] xs;
      logic signed [CW-1:0] ys;
      assign xs = x_s[i] >>> i;
      assign ys = y_s[i] >>> i;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          zv_s[i+1] <= zv_s[i];
          if (!y_s[i][CW-1]) begin
            x_s[i+1] <= x_s[i] + ys;
            y_s[i+1] <= y_s[i] - xs;
            z_s[i+1] <= z_s[i] + atan_q30(5'(i));
          end else begin
            x_s[i+1] <= x_s[i] - ys;
            y_s[i+1] <= y_s[i] + xs;
            z_s[i+1] <= z_s[i] - atan_q30(5'(i));
          end
        end
      end
    end

    assign q = (z_s[CORDIC_STEPS] + ROUND_ADD) >>> 17;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (zv_s[CORDIC_STEPS]) begin
          ang_q <= '0;
        end else if (q > ANGLE_MAX) begin
          ang_q <= AW'(ANGLE_MAX);
        end else if (q < ANGLE_MIN) begin
          ang_q <= AW'(ANGLE_MIN);
        end else begin
          ang_q <= AW'(q);
        end
      end
    end

    assign angle_o[l] = ang_q;
  end

  assign valid_o = valid_s[LAST];
  assign pos_o   = pos_s[LAST];

endmodule
